/* rtl/bvp_pkg.sv */
// Shared types and constants for the button volume/pause controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bvp_pkg;

	localparam int unsigned ATT_W   = 7;
	localparam int unsigned CNT_W   = 20;
	localparam int unsigned SMP_W   = 12;
	localparam int unsigned RATE_W  = 18;
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned DATA_W  = 32;

	localparam logic [ATT_W-1:0] ATT_CEIL  = 7'd96;
	localparam logic [ATT_W-1:0] ATT_FLOOR = 7'd3;
	localparam logic [ATT_W-1:0] ATT_STEP  = 7'd4;
	localparam logic [ATT_W-1:0] ATT_RESET = 7'd24;

	// register index, taken from paddr above the byte offset
	localparam logic [ADDR_W-3:0] REG_INIT_ATT = 1'b0;

	typedef struct packed {
		logic              next_level;
		logic              pause_level;
		logic              volume_level;
		logic [SMP_W-1:0]  samples;
		logic [RATE_W-1:0] sample_rate;
	} item_t;

	typedef struct packed {
		logic             paused;
		logic             skip_track;
		logic [ATT_W-1:0] attenuation;
	} result_t;

	typedef struct packed {
		logic             prev_next;
		logic             prev_pause;
		logic             prev_volume;
		logic             pause_flag;
		logic             holding;
		logic             no_repeat_yet;
		logic             click_pending;
		logic [CNT_W-1:0] hold_countdown;
		logic [ATT_W-1:0] att_level;
	} state_t;

	typedef struct packed {
		logic             load;
		logic [ATT_W-1:0] value;
	} cfg_wr_t;

endpackage

/* rtl/bvp_apb.sv */
// APB register slave holding the initial attenuation register.
// Depends on bvp_pkg; emits a load strobe for the live attenuation level.
`timescale 1ns / 1ps

module bvp_apb (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bvp_pkg::ADDR_W-1:0]   paddr,
	input  logic [bvp_pkg::DATA_W-1:0]   pwdata,
	output logic [bvp_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output bvp_pkg::cfg_wr_t             cfg_wr
);
	import bvp_pkg::*;

	logic [ATT_W-1:0]  init_att_q;
	logic [ADDR_W-3:0] reg_idx;
	logic              wr_hit;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];

	// decode a completed write transfer and drive the read data
	always_comb begin
		wr_hit = 1'b0;
		prdata = '0;
		unique case (reg_idx)
			REG_INIT_ATT: begin
				wr_hit = psel & penable & pwrite;
				prdata = {{(DATA_W-ATT_W){1'b0}}, init_att_q};
			end
			default: begin
				wr_hit = 1'b0;
				prdata = '0;
			end
		endcase
	end

	// hold the register value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_att_q <= ATT_RESET;
		end else if (wr_hit) begin
			init_att_q <= pwdata[ATT_W-1:0];
		end
	end

	assign cfg_wr.load  = wr_hit;
	assign cfg_wr.value = pwdata[ATT_W-1:0];

endmodule

/* rtl/bvp_step.sv */
// Next-state and result logic for one button sample.
// Depends on bvp_pkg; purely combinational.
`timescale 1ns / 1ps

module bvp_step (
	input  bvp_pkg::state_t  cur,
	input  bvp_pkg::item_t   item,
	output bvp_pkg::state_t  nxt,
	output bvp_pkg::result_t res
);
	import bvp_pkg::*;

	logic             skip;
	logic             v_press;
	logic             v_release;
	logic [CNT_W-1:0] half_rate;
	logic [CNT_W-1:0] smp;

	always_comb begin
		half_rate = {{(CNT_W-RATE_W+1){1'b0}}, item.sample_rate[RATE_W-1:1]};
		smp       = {{(CNT_W-SMP_W){1'b0}}, item.samples};
		nxt       = cur;

		// next press clears pause and pulses skip
		skip = ~item.next_level & cur.prev_next;
		if (skip) begin
			nxt.pause_flag = 1'b0;
		end
		nxt.prev_next = item.next_level;

		// pause press toggles pause
		if (~item.pause_level & cur.prev_pause) begin
			nxt.pause_flag = ~nxt.pause_flag;
		end
		nxt.prev_pause = item.pause_level;

		// volume press arms the hold countdown
		v_press   = ~item.volume_level & cur.prev_volume;
		v_release = item.volume_level & ~cur.prev_volume;
		if (v_press) begin
			nxt.hold_countdown = half_rate;
			nxt.holding        = 1'b1;
			nxt.no_repeat_yet  = 1'b1;
			nxt.click_pending  = 1'b1;
		end
		if (v_release) begin
			nxt.hold_countdown = '0;
			nxt.holding        = 1'b0;
		end
		nxt.prev_volume = item.volume_level;

		// count down while held; on expiry step up and reload
		if (nxt.holding) begin
			if (nxt.hold_countdown != '0) begin
				nxt.hold_countdown = (nxt.hold_countdown > smp) ?
					nxt.hold_countdown - smp : '0;
			end else begin
				nxt.no_repeat_yet  = 1'b0;
				nxt.hold_countdown = half_rate;
				if (nxt.att_level < ATT_CEIL) begin
					nxt.att_level = nxt.att_level + ATT_STEP;
				end
			end
		end

		// short click steps down once
		if (!nxt.holding && nxt.no_repeat_yet && nxt.click_pending) begin
			nxt.click_pending = 1'b0;
			if (nxt.att_level > ATT_FLOOR) begin
				nxt.att_level = nxt.att_level - ATT_STEP;
			end
		end

		res.paused      = nxt.pause_flag;
		res.skip_track  = skip;
		res.attenuation = nxt.att_level;
	end

endmodule

/* rtl/button_volume_pause_controller_core.sv */
// Top level of the button volume/pause controller: input register, state,
// result register. Depends on bvp_pkg, bvp_apb and bvp_step.
//
// channel | direction | handshake           | payload
// in      | to block  | in_valid / in_stall   | next_level pause_level volume_level samples sample_rate
// out     | from block| out_valid / out_stall | paused skip_track attenuation
// cfg     | to block  | APB psel/penable      | initial_attenuation at byte address 0
//
// One item per cycle while the result is not stalled; items pass the input register, then the result register.
// The state update is one combinational pass between the input register and the result.
// Reset clears the flags and countdown, sets the previous button levels high and attenuation to ATT_RESET (24).
// A stalled result holds; the input register keeps accepting while it can move forward.
`timescale 1ns / 1ps

module button_volume_pause_controller_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          next_level,
	input  logic                          pause_level,
	input  logic                          volume_level,
	input  logic [bvp_pkg::SMP_W-1:0]     samples,
	input  logic [bvp_pkg::RATE_W-1:0]    sample_rate,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          paused,
	output logic                          skip_track,
	output logic [bvp_pkg::ATT_W-1:0]     attenuation,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bvp_pkg::ADDR_W-1:0]    paddr,
	input  logic [bvp_pkg::DATA_W-1:0]    pwdata,
	output logic [bvp_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import bvp_pkg::*;

	cfg_wr_t cfg_wr;
	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	logic    in_xfer;

	bvp_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg_wr  (cfg_wr)
	);

	bvp_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	assign advance  = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign in_xfer  = in_valid & ~in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= '{next_level, pause_level, volume_level, samples, sample_rate};
		end
	end

	// controller state; a register write reloads the level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{prev_next: 1'b1, prev_pause: 1'b1, prev_volume: 1'b1,
				pause_flag: 1'b0, holding: 1'b0, no_repeat_yet: 1'b0,
				click_pending: 1'b0, hold_countdown: '0, att_level: ATT_RESET};
		end else if (cfg_wr.load) begin
			state_q.att_level <= cfg_wr.value;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign paused      = res_s2.paused;
	assign skip_track  = res_s2.skip_track;
	assign attenuation = res_s2.attenuation;

endmodule

/* rtl/bvp_checker.sv */
// Port-level checks for the controller top level, attached by bind.
// Depends on bvp_pkg for widths.
`timescale 1ns / 1ps

module bvp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       paused,
	input logic                       skip_track,
	input logic [bvp_pkg::ATT_W-1:0]  attenuation,
	input logic                       pready
);
	import bvp_pkg::*;

	logic [1:0] inflight_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid & ~in_stall;
	assign out_xfer = out_valid & ~out_stall;

	// track items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + {1'b0, in_xfer} - {1'b0, out_xfer};
		end
	end

	// input only backs up behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled result");

	// never more than the two register stages in flight
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3)
		else $error("more items in flight than stages");

	// no result without a transfer behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (inflight_q != 2'd0))
		else $error("result shown with nothing in flight");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(paused) && $stable(skip_track) && $stable(attenuation)))
		else $error("stalled result changed");

	// register port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind button_volume_pause_controller_core bvp_checker u_bvp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.paused      (paused),
	.skip_track  (skip_track),
	.attenuation (attenuation),
	.pready      (pready)
);
